// ===== sv/gpv_pkg.sv =====
// Shared constants, types and helpers for the grid path validator.
// No dependencies; every other file of the block refers to this package by scope.
package gpv_pkg;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 64;
   localparam int CELLS    = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W   = $clog2(CELLS);

   // fixed field widths of the channels
   localparam int ROW_W    = 6;
   localparam int COL_W    = 6;
   localparam int SIZE_W   = 7;
   localparam int STATUS_W = 3;

   // path tag kept per visited entry; tag 0 means never visited
   localparam int TAG_W = 8;
   localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
   localparam logic [TAG_W-1:0] TAG_LAST  = {TAG_W{1'b1}};

   localparam logic OP_CELL = 1'b0;
   localparam logic OP_STEP = 1'b1;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = 1'b1;

   localparam logic [STATUS_W-1:0] ST_PENDING   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_VALID     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_EXIT  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_ENTRY = 3'd3;
   localparam logic [STATUS_W-1:0] ST_ILLEGAL   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_REVISIT   = 3'd5;

   typedef struct packed {
      logic              maze_we;
      logic [ADDR_W-1:0] maze_waddr;
      logic              maze_wdata;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              vis_we;
      logic [ADDR_W-1:0] vis_waddr;
      logic [TAG_W-1:0]  vis_wtag;
      logic              clear;
   } store_req_type;

   typedef struct packed {
      logic             busy;
      logic             maze_q;
      logic [TAG_W-1:0] vis_q;
   } store_rsp_type;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(int'(row) * MAX_COLS + int'(col));
   endfunction

   // 0 acts as 1, anything above the storage size acts as the storage size
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v, input int maxv);
      logic [SIZE_W-1:0] r;
      if (v == '0) r = SIZE_W'(1);
      else if (int'(v) > maxv) r = SIZE_W'(maxv);
      else r = v;
      return r;
   endfunction

endpackage

// ===== sv/gpv_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on gpv_pkg for the field widths.
interface gpv_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [gpv_pkg::ROW_W-1:0]  step_row;
   logic [gpv_pkg::COL_W-1:0]  step_col;
   logic                       cell_open;
   logic                       path_last;

   modport source(output valid, op, step_row, step_col, cell_open, path_last,
                  input ready);
   modport sink(input valid, op, step_row, step_col, cell_open, path_last,
                output ready);
endinterface

interface gpv_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gpv_pkg::STATUS_W-1:0]  status;
   logic                          path_done;

   modport source(output valid, status, path_done, input ready);
   modport sink(input valid, status, path_done, output ready);
endinterface

// ===== sv/gpv_store.sv =====
// Maze cell memory and visited-tag memory, both with registered read data,
// plus the sweep that zeroes the visited tags. Depends on gpv_pkg.
module gpv_store (
   input  logic                   clock,
   input  logic                   reset,
   input  gpv_pkg::store_req_type req,
   output gpv_pkg::store_rsp_type rsp
);

   logic                         maze_mem [gpv_pkg::CELLS];
   logic [gpv_pkg::TAG_W-1:0]    vis_mem  [gpv_pkg::CELLS];
   logic                         maze_q_ff;
   logic [gpv_pkg::TAG_W-1:0]    vis_q_ff;
   logic                         clr_busy_ff, clr_busy_in;
   logic [gpv_pkg::ADDR_W-1:0]   clr_addr_ff, clr_addr_in;

   always_ff @(posedge clock) begin
      if (req.maze_we) maze_mem[req.maze_waddr] <= req.maze_wdata;
      if (req.rd_en) maze_q_ff <= maze_mem[req.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) vis_mem[clr_addr_ff] <= '0;
      else if (req.vis_we) vis_mem[req.vis_waddr] <= req.vis_wtag;
      if (req.rd_en) vis_q_ff <= vis_mem[req.rd_addr];
   end

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == gpv_pkg::ADDR_W'(gpv_pkg::CELLS - 1)) clr_busy_in = 1'b0;
      end else if (req.clear) begin
         clr_busy_in = 1'b1;
         clr_addr_in = '0;
      end
   end

   // sweep runs right after reset and again on each clear request
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign rsp.busy   = clr_busy_ff;
   assign rsp.maze_q = maze_q_ff;
   assign rsp.vis_q  = vis_q_ff;

endmodule

// ===== sv/grid_path_validator.sv =====
// Grid path validator: one cell write or one path step per cycle when not
// stalled; a step's response is registered and shows in the next cycle.
// Each step reads its own maze cell and visited tag; it is judged when the
// next step arrives, from the read data or the copy held since then.
// Synchronous active-high reset; afterwards, and again after every 255th path
// ends, a sweep zeroes every visited tag and holds off requests.
module grid_path_validator (
   input  logic                         clock,
   input  logic                         reset,
   gpv_req_if.sink                      req_ch,
   gpv_rsp_if.source                    rsp_ch,
   input  logic                         csr_we,
   input  logic [gpv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gpv_pkg::SIZE_W-1:0]   csr_wdata
);

   gpv_pkg::store_req_type st_req;
   gpv_pkg::store_rsp_type st_rsp;

   logic [gpv_pkg::SIZE_W-1:0]   rows_ff, rows_in, cols_ff, cols_in;
   logic [gpv_pkg::ROW_W-1:0]    prev_row_ff, prev_row_in;
   logic [gpv_pkg::COL_W-1:0]    prev_col_ff, prev_col_in;
   logic                         have_prev_ff, have_prev_in;
   logic [gpv_pkg::STATUS_W-1:0] err_ff, err_in;
   logic [gpv_pkg::TAG_W-1:0]    epoch_ff, epoch_in;
   logic                         fresh_ff, fresh_in;
   logic                         held_open_ff, held_open_in;
   logic                         held_vis_ff, held_vis_in;
   logic                         out_valid_ff, out_valid_in;
   logic [gpv_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic                         out_done_ff, out_done_in;

   logic                         ready, acc, step_acc, cell_acc;
   logic                         cur_open, cur_vis, is_exit, inb, adj, mark_ok, hit;
   logic [gpv_pkg::ROW_W-1:0]    dr;
   logic [gpv_pkg::COL_W-1:0]    dc;
   logic [gpv_pkg::STATUS_W-1:0] err_a, fin;

   gpv_store u_store (
      .clock (clock),
      .reset (reset),
      .req   (st_req),
      .rsp   (st_rsp)
   );

   assign ready    = !st_rsp.busy && (!out_valid_ff || rsp_ch.ready);
   assign acc      = req_ch.valid && ready;
   assign step_acc = acc && (req_ch.op == gpv_pkg::OP_STEP);
   assign cell_acc = acc && (req_ch.op == gpv_pkg::OP_CELL);

   // read data is used in the cycle after a step's read; later, the held copy
   assign cur_open = fresh_ff ? st_rsp.maze_q : held_open_ff;
   assign cur_vis  = fresh_ff ? (st_rsp.vis_q == epoch_ff) : held_vis_ff;

   assign is_exit = ({1'b0, req_ch.step_row} == rows_ff - 1'b1)
                 && ({1'b0, req_ch.step_col} == cols_ff - 1'b1);
   assign inb = ({1'b0, prev_row_ff} < rows_ff) && ({1'b0, prev_col_ff} < cols_ff);
   assign dr  = (prev_row_ff > req_ch.step_row) ? prev_row_ff - req_ch.step_row
                                                : req_ch.step_row - prev_row_ff;
   assign dc  = (prev_col_ff > req_ch.step_col) ? prev_col_ff - req_ch.step_col
                                                : req_ch.step_col - prev_col_ff;
   assign adj = ((dr == gpv_pkg::ROW_W'(1)) && (dc == '0))
             || ((dr == '0) && (dc == gpv_pkg::COL_W'(1)));

   // a cell write to the step waiting for judgment updates its held copy
   assign hit = cell_acc && have_prev_ff && (req_ch.step_row == prev_row_ff)
             && (req_ch.step_col == prev_col_ff);

   always_comb begin
      mark_ok = 1'b0;
      err_a   = err_ff;
      if (!have_prev_ff) begin
         err_a = is_exit ? gpv_pkg::ST_PENDING : gpv_pkg::ST_NOT_EXIT;
      end else if (err_ff == gpv_pkg::ST_PENDING) begin
         if (!inb || !adj || !cur_open) err_a = gpv_pkg::ST_ILLEGAL;
         else if (cur_vis) err_a = gpv_pkg::ST_REVISIT;
         else mark_ok = 1'b1;
      end
      fin = err_a;
      if (err_a == gpv_pkg::ST_PENDING && (req_ch.step_row != '0 || req_ch.step_col != '0))
         fin = gpv_pkg::ST_NOT_ENTRY;
   end

   always_comb begin
      st_req.maze_we    = cell_acc && (int'(req_ch.step_row) < gpv_pkg::MAX_ROWS)
                       && (int'(req_ch.step_col) < gpv_pkg::MAX_COLS);
      st_req.maze_waddr = gpv_pkg::cell_addr(req_ch.step_row, req_ch.step_col);
      st_req.maze_wdata = req_ch.cell_open;
      st_req.rd_en      = step_acc;
      st_req.rd_addr    = gpv_pkg::cell_addr(req_ch.step_row, req_ch.step_col);
      st_req.vis_we     = step_acc && mark_ok;
      st_req.vis_waddr  = gpv_pkg::cell_addr(prev_row_ff, prev_col_ff);
      st_req.vis_wtag   = epoch_ff;
      st_req.clear      = step_acc && req_ch.path_last && (epoch_ff == gpv_pkg::TAG_LAST);
   end

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         unique case (csr_index)
            gpv_pkg::CSR_ROWS: rows_in = gpv_pkg::eff_size(csr_wdata, gpv_pkg::MAX_ROWS);
            gpv_pkg::CSR_COLS: cols_in = gpv_pkg::eff_size(csr_wdata, gpv_pkg::MAX_COLS);
         endcase
      end
   end

   always_comb begin
      prev_row_in   = prev_row_ff;
      prev_col_in   = prev_col_ff;
      have_prev_in  = have_prev_ff;
      err_in        = err_ff;
      epoch_in      = epoch_ff;
      fresh_in      = step_acc && !req_ch.path_last;
      held_open_in  = hit ? req_ch.cell_open : cur_open;
      held_vis_in   = cur_vis;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_status_in = out_status_ff;
      out_done_in   = out_done_ff;
      if (step_acc) begin
         out_valid_in = 1'b1;
         if (req_ch.path_last) begin
            prev_row_in   = '0;
            prev_col_in   = '0;
            have_prev_in  = 1'b0;
            err_in        = gpv_pkg::ST_PENDING;
            epoch_in      = (epoch_ff == gpv_pkg::TAG_LAST) ? gpv_pkg::TAG_FIRST
                                                           : epoch_ff + 1'b1;
            out_status_in = (fin == gpv_pkg::ST_PENDING) ? gpv_pkg::ST_VALID : fin;
            out_done_in   = 1'b1;
         end else begin
            prev_row_in   = req_ch.step_row;
            prev_col_in   = req_ch.step_col;
            have_prev_in  = 1'b1;
            err_in        = err_a;
            out_status_in = err_a;
            out_done_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= gpv_pkg::SIZE_W'(1);
         cols_ff      <= gpv_pkg::SIZE_W'(1);
         prev_row_ff  <= '0;
         prev_col_ff  <= '0;
         have_prev_ff <= 1'b0;
         err_ff       <= gpv_pkg::ST_PENDING;
         epoch_ff     <= gpv_pkg::TAG_FIRST;
         fresh_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         prev_row_ff  <= prev_row_in;
         prev_col_ff  <= prev_col_in;
         have_prev_ff <= have_prev_in;
         err_ff       <= err_in;
         epoch_ff     <= epoch_in;
         fresh_ff     <= fresh_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_open_ff  <= held_open_in;
      held_vis_ff   <= held_vis_in;
      out_status_ff <= out_status_in;
      out_done_ff   <= out_done_in;
   end

   assign req_ch.ready     = ready;
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.status    = out_status_ff;
   assign rsp_ch.path_done = out_done_ff;

endmodule

// ===== sv/gpv_checker.sv =====
// Port-level checks for the grid path validator, bound to the top level.
// Depends on gpv_pkg and on the top level's channel ports.
module gpv_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_op,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [gpv_pkg::STATUS_W-1:0] rsp_status,
   input logic                         rsp_path_done
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_path_done))
      else $error("response changed while stalled");

   // every step transfer gives a response in the next cycle
   a_step_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == gpv_pkg::OP_STEP |=> rsp_valid)
      else $error("step transfer without response");

   // a cell write into an empty output stage gives no response
   a_cell_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == gpv_pkg::OP_CELL && !rsp_valid |=> !rsp_valid)
      else $error("cell write produced a response");

   // valid and not-entry appear only on the final step, which never reports pending
   a_mid_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_path_done |-> rsp_status != gpv_pkg::ST_VALID
                                   && rsp_status != gpv_pkg::ST_NOT_ENTRY)
      else $error("final verdict on an inner step");

   a_end_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_path_done |-> rsp_status != gpv_pkg::ST_PENDING)
      else $error("final step reported pending");

endmodule

bind grid_path_validator gpv_checker u_gpv_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .req_op        (req_ch.op),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_path_done (rsp_ch.path_done)
);
